>>> rtl/omni_wheel_odometry_macros.svh
// Assertion macros shared by the odometry block.
`ifndef OMNI_WHEEL_ODOMETRY_MACROS_SVH
`define OMNI_WHEEL_ODOMETRY_MACROS_SVH
`define OWO_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: check failed");
`define OWO_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: check failed");
`endif

>>> rtl/owo_pkg.sv
// Types and constants for the omni wheel odometry block.
package owo_pkg;
    localparam logic [15:0] RADIUS_RESET = 16'd1248;
    localparam logic [15:0] K_X          = 16'd37792;
    localparam logic [15:0] K_TWO_THIRDS = 16'd43691;
    localparam logic [30:0] K_GAIN       = 31'd652032874;
    localparam int          ATAN_ENTRIES = 24;
    localparam int          VW           = 50;

    typedef struct packed {
        logic load;
        logic body;
        logic heading;
        logic mul_gain;
        logic pre_rot;
        logic step;
        logic fin_vel;
        logic fin_pos;
    } t_cmd;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051D;
            5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage

>>> rtl/owo_ctrl.sv
// Sequencer for the odometry datapath.
module owo_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_operation,
    output owo_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_ready
);
    import owo_pkg::*;

    localparam int         NS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic [2:0] S_IDLE = 3'd0, S_GAIN = 3'd1, S_PRE = 3'd2, S_ROT = 3'd3,
                           S_VEL = 3'd4, S_POS = 3'd5, S_OUT = 3'd6, S_BODY = 3'd7;

    logic [2:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load    = !i_operation;
                    o_cmd.heading = i_operation;
                    n_state       = i_operation ? S_OUT : S_BODY;
                end
            end
            S_BODY: begin
                o_cmd.body = 1'b1;
                n_state    = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul_gain = 1'b1;
                n_state        = S_PRE;
            end
            S_PRE: begin
                o_cmd.pre_rot = 1'b1;
                n_cnt         = '0;
                n_state       = S_ROT;
            end
            S_ROT: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 5'd1;
                if (r_cnt == 5'(NS - 1)) begin
                    n_state = S_VEL;
                end
            end
            S_VEL: begin
                o_cmd.fin_vel = 1'b1;
                n_state       = S_POS;
            end
            S_POS: begin
                o_cmd.fin_pos = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

>>> rtl/owo_datapath.sv
// Arithmetic and state registers of the odometry block.
module owo_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  owo_pkg::t_cmd       i_cmd,
    input  logic [15:0]         i_radius,
    input  logic signed [23:0]  i_left_rate,
    input  logic signed [23:0]  i_right_rate,
    input  logic signed [23:0]  i_back_rate,
    input  logic [15:0]         i_elapsed,
    input  logic signed [15:0]  i_yaw,
    output logic signed [23:0]  o_velocity_x,
    output logic signed [23:0]  o_velocity_y,
    output logic signed [39:0]  o_position_x,
    output logic signed [39:0]  o_position_y,
    output logic signed [15:0]  o_heading
);
    import owo_pkg::*;

    logic signed [VW-1:0] r_x, r_y;
    logic signed [33:0]   r_z;
    logic [4:0]           r_i;
    logic [15:0]          r_dt;
    logic signed [23:0]   r_vx, r_vy;
    logic signed [39:0]   r_px, r_py;
    logic signed [15:0]   r_head, r_off;
    logic                 r_taken;

    // Rim speed combinations at load; the combining constants are applied in the body step that follows.
    logic signed [40:0] vl, vr, vb;
    logic signed [43:0] dxr, sby;
    always_comb begin
        vl  = 41'(i_left_rate * $signed({1'b0, i_radius}));
        vr  = 41'(i_right_rate * $signed({1'b0, i_radius}));
        vb  = 41'(i_back_rate * $signed({1'b0, i_radius}));
        dxr = 44'(vr) - 44'(vl);
        sby = 44'(vb) + 44'(vb) - 44'(vl) - 44'(vr);
    end

    logic signed [61:0] px, py;
    logic signed [VW-1:0] bx, by;
    assign px = 62'(44'(r_x) * $signed({1'b0, K_X})) + 62'sd8388608;
    assign py = 62'(44'(r_y) * $signed({1'b0, K_TWO_THIRDS})) + 62'sd16777216;
    assign bx = VW'(px >>> 24);
    assign by = VW'(py >>> 25);

    logic signed [64:0] gx, gy;
    assign gx = 65'(33'(r_x) * $signed({1'b0, K_GAIN})) + 65'sd536870912;
    assign gy = 65'(33'(r_y) * $signed({1'b0, K_GAIN})) + 65'sd536870912;

    logic signed [VW-1:0] sx, sy;
    logic [31:0]          at;
    assign sx = r_y >>> r_i;
    assign sy = r_x >>> r_i;
    assign at = atan_turns(r_i);

    logic signed [VW-1:0] rx, ry;
    assign rx = (r_x + VW'(128)) >>> 8;
    assign ry = (r_y + VW'(128)) >>> 8;

    function automatic logic signed [23:0] sat24(input logic signed [VW-1:0] v);
        if (v > VW'(24'sh7FFFFF)) return 24'sh7FFFFF;
        if (v < -VW'(24'sh800000) + VW'(0) && v < VW'(-64'sd8388608)) return 24'sh800000;
        return v[23:0];
    endfunction

    logic signed [40:0] mx, my, ax, ay;
    assign mx = 41'(r_vx * $signed({1'b0, r_dt})) + 41'sd128;
    assign my = 41'(r_vy * $signed({1'b0, r_dt})) + 41'sd128;
    assign ax = 41'(r_px) + 41'(mx >>> 8);
    assign ay = 41'(r_py) + 41'(my >>> 8);

    function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
        if (v[40] != v[39]) return v[40] ? {1'b1, 39'h0} : {1'b0, {39{1'b1}}};
        return v[39:0];
    endfunction

    logic signed [15:0] ang;
    assign ang = r_head;
    logic far;
    assign far = (ang >= 16'sh4000) || (ang < -16'sh4000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= '0; r_vy <= '0; r_px <= '0; r_py <= '0;
            r_head <= '0; r_off <= '0; r_taken <= 1'b0;
        end else begin
            if (i_cmd.heading) begin
                if (!r_taken) begin
                    r_taken <= 1'b1;
                    r_off   <= i_yaw;
                    r_head  <= '0;
                end else begin
                    r_head <= i_yaw - r_off;
                end
            end
            if (i_cmd.fin_vel) begin
                r_vx <= sat24(rx);
                r_vy <= sat24(ry);
            end
            if (i_cmd.fin_pos) begin
                r_px <= sat40(ax);
                r_py <= sat40(ay);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= VW'(dxr);
            r_y  <= VW'(sby);
            r_dt <= i_elapsed;
        end
        if (i_cmd.body) begin
            r_x <= bx;
            r_y <= by;
        end
        if (i_cmd.mul_gain) begin
            r_x <= VW'(gx >>> 30);
            r_y <= VW'(gy >>> 30);
        end
        if (i_cmd.pre_rot) begin
            r_i <= '0;
            if (far) begin
                r_x <= -r_x;
                r_y <= -r_y;
                r_z <= 34'(ang >= 0 ? 17'(ang) - 17'sh8000 : 17'(ang) + 17'sh8000) <<< 16;
            end else begin
                r_z <= 34'(ang) <<< 16;
            end
        end
        if (i_cmd.step) begin
            r_i <= r_i + 5'd1;
            if (!r_z[33]) begin
                r_x <= r_x - sx;
                r_y <= r_y + sy;
                r_z <= r_z - $signed({2'b0, at});
            end else begin
                r_x <= r_x + sx;
                r_y <= r_y - sy;
                r_z <= r_z + $signed({2'b0, at});
            end
        end
    end

    assign o_velocity_x = r_vx;
    assign o_velocity_y = r_vy;
    assign o_position_x = r_px;
    assign o_position_y = r_py;
    assign o_heading    = r_head;
endmodule

>>> rtl/omni_wheel_odometry.sv
// Top level of the omni wheel odometry block.
// Use: a request on the input channel carries either a wheel sample (operation 0:
// three wheel rates and the elapsed time) or a heading sample (operation 1: yaw).
// Every request yields one result carrying world velocity, position and heading.
// The wheel radius register is written through i_cfg_we; the user must write it
// only while the block is idle, the block itself does not enforce this. A wheel
// request runs through the body transform, gain, pre-rotation, CORDIC_STEPS
// iterations at one per cycle (capped at the arctangent table size), velocity
// and position updates. A heading request gives its result in the cycle after
// acceptance. One request is in flight at a time; the next is taken the cycle
// after the result is taken. While the receiver stalls the result is held stable
// and no request is taken. Reset clears position, velocity, heading and the yaw
// offset latch and sets the radius to its default.
module omni_wheel_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic signed [23:0] i_left_rate,
    input  logic signed [23:0] i_right_rate,
    input  logic signed [23:0] i_back_rate,
    input  logic [15:0]        i_elapsed,
    input  logic signed [15:0] i_yaw,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_velocity_x,
    output logic signed [23:0] o_velocity_y,
    output logic signed [39:0] o_position_x,
    output logic signed [39:0] o_position_y,
    output logic signed [15:0] o_heading
);
    import owo_pkg::*;
`include "omni_wheel_odometry_macros.svh"

    logic [15:0] r_radius;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    owo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation,
        .o_cmd(cmd), .o_valid, .i_ready
    );

    owo_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_radius(r_radius),
        .i_left_rate, .i_right_rate, .i_back_rate, .i_elapsed, .i_yaw,
        .o_velocity_x, .o_velocity_y, .o_position_x, .o_position_y, .o_heading
    );

    `OWO_ASSERT_IMP(a_no_ready_when_valid, i_clk, i_rst_n, o_valid, !o_ready)
    `OWO_ASSERT_NXT(a_hold_stall, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_position_x))
    `OWO_ASSERT_NXT(a_heading_fast, i_clk, i_rst_n, i_valid && o_ready && i_operation, o_valid)
endmodule
